// ----- rtl/pll_divider_search_top_macros.svh -----
// assertion macros for the checker file
`ifndef PLL_DIVIDER_SEARCH_TOP_MACROS_SVH
`define PLL_DIVIDER_SEARCH_TOP_MACROS_SVH

// checked property, disabled while reset is asserted
`define PDS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked property, also evaluated during reset
`define PDS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ----- rtl/pds_pkg.sv -----
// shared types and constants of the pll divider search block
package pds_pkg;

  localparam int unsigned REF_W     = 32;
  localparam int unsigned VCO_W     = 33;
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned DVD_W     = VCO_W + FRAC_W;
  localparam int unsigned DVS_W     = REF_W;
  localparam int unsigned STEP_W    = $clog2(DVD_W + 1);

  localparam int unsigned MAX_PREDIV_DEF = 32;

  localparam logic [REF_W-1:0] REF_RESET   = 32'd25000000;
  localparam logic [VCO_W-1:0] THRESH_LOW  = 33'd3750000000;
  localparam logic [VCO_W-1:0] THRESH_HIGH = 33'd4000000000;
  localparam logic [15:0]      MINT_MIN    = 16'd16;

  localparam logic [STEP_W-1:0] STEPS_REF = STEP_W'(REF_W);
  localparam logic [STEP_W-1:0] STEPS_VCO = STEP_W'(DVD_W);

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_PDIV  = 2'd1,
    ST_DIV_ZERO = 2'd2
  } status_e;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } div_req_t;

endpackage

// ----- rtl/pds_serdiv.sv -----
// bit-serial restoring divider, one quotient bit per cycle
module pds_serdiv (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  pds_pkg::div_req_t            req_i,
  input  logic [pds_pkg::DVD_W-1:0]    dividend_i,
  input  logic [pds_pkg::DVS_W-1:0]    divisor_i,
  output logic                         done_o,
  output logic [pds_pkg::DVD_W-1:0]    quotient_o
);

  logic [pds_pkg::DVD_W-1:0]  dvd_q, dvd_d;
  logic [pds_pkg::DVS_W-1:0]  dvs_q;
  logic [pds_pkg::DVS_W-1:0]  rem_q, rem_d;
  logic [pds_pkg::STEP_W-1:0] cnt_q;
  logic                       busy_q, done_q;
  logic [pds_pkg::DVS_W:0]    shifted;
  logic [pds_pkg::DVS_W:0]    diff;
  logic                       ge;

  // dividend shifts out at the top while quotient bits shift in at the bottom
  always_comb begin
    shifted = {rem_q, dvd_q[pds_pkg::DVD_W-1]};
    diff    = shifted - {1'b0, dvs_q};
    ge      = (shifted >= {1'b0, dvs_q});
    rem_d   = ge ? diff[pds_pkg::DVS_W-1:0] : shifted[pds_pkg::DVS_W-1:0];
    dvd_d   = {dvd_q[pds_pkg::DVD_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= req_i.steps;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == pds_pkg::STEP_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;

endmodule

// ----- rtl/pll_divider_search_top.sv -----
// Converts a requested VCO frequency into PLL predivider and feedback divider
// codes. Each predivider p from 1 up to MAX_PREDIV is tried in turn on one
// shared bit-serial divider: first ref_clock_hz / p, then (vco_hz << 16) / d,
// with a start and done handshake around each division, until a candidate
// gives a large enough integer code or the last predivider has been tried.
// A new item is taken whenever the search is idle, even while the previous
// result is still waiting in the output register.
module pll_divider_search_top #(
  parameter int unsigned MAX_PREDIV = pds_pkg::MAX_PREDIV_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        ref_clock_hz_we_i,
  input  logic [pds_pkg::REF_W-1:0]   ref_clock_hz_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [pds_pkg::VCO_W-1:0]   vco_hz_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [4:0]                  prediv_code_o,
  output logic [15:0]                 int_code_o,
  output logic [15:0]                 frac_part_o,
  output logic                        vco_mode_on_o,
  output logic                        low_freq_on_o,
  output logic [1:0]                  status_o
);

  localparam int unsigned PW = $clog2(MAX_PREDIV + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DREF,
    S_DVCO,
    S_DONE
  } state_e;

  state_e                        state_q;
  logic [pds_pkg::REF_W-1:0]     ref_q;
  logic [pds_pkg::VCO_W-1:0]     vco_q;
  logic [PW-1:0]                 p_q;
  pds_pkg::div_req_t             div_req_q;
  logic [pds_pkg::DVD_W-1:0]     div_dvd_q;
  logic [pds_pkg::DVS_W-1:0]     div_dvs_q;
  logic                          div_done;
  logic [pds_pkg::DVD_W-1:0]     div_quot;
  logic [31:0]                   quot_lo;
  logic [PW+4:0]                 pm1_ext;
  logic [15:0]                   mint;

  logic                          mode_q, lowf_q;
  logic [4:0]                    pcode_q;
  logic [15:0]                   icode_q, frac_q;
  pds_pkg::status_e              status_q;

  logic                          out_valid_q;
  logic [4:0]                    out_pcode_q;
  logic [15:0]                   out_icode_q, out_frac_q;
  logic                          out_mode_q, out_lowf_q;
  pds_pkg::status_e              out_status_q;

  pds_serdiv u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req_q),
    .dividend_i (div_dvd_q),
    .divisor_i  (div_dvs_q),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  assign quot_lo = div_quot[31:0];
  assign mint    = quot_lo[31:16];
  assign pm1_ext = {5'b0, p_q - PW'(1)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q <= pds_pkg::REF_RESET;
    end else if (ref_clock_hz_we_i) begin
      ref_q <= ref_clock_hz_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      div_req_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          div_req_q.start <= in_valid_i;
          if (in_valid_i) begin
            vco_q           <= vco_hz_i;
            mode_q          <= (vco_hz_i < pds_pkg::THRESH_HIGH);
            lowf_q          <= (vco_hz_i <= pds_pkg::THRESH_LOW) ||
                               (vco_hz_i >= pds_pkg::THRESH_HIGH);
            p_q             <= PW'(1);
            div_dvd_q       <= {ref_q, (pds_pkg::DVD_W - pds_pkg::REF_W)'(0)};
            div_dvs_q       <= pds_pkg::DVS_W'(1);
            div_req_q.steps <= pds_pkg::STEPS_REF;
            state_q         <= S_DREF;
          end
        end
        S_DREF: begin
          div_req_q.start <= div_done && (quot_lo != '0);
          if (div_done) begin
            if (quot_lo == '0) begin
              pcode_q  <= '0;
              icode_q  <= '0;
              frac_q   <= '0;
              status_q <= pds_pkg::ST_DIV_ZERO;
              state_q  <= S_DONE;
            end else begin
              div_dvd_q       <= {vco_q, pds_pkg::FRAC_W'(0)};
              div_dvs_q       <= quot_lo;
              div_req_q.steps <= pds_pkg::STEPS_VCO;
              state_q         <= S_DVCO;
            end
          end
        end
        S_DVCO: begin
          div_req_q.start <= div_done && (mint < pds_pkg::MINT_MIN) &&
                             (p_q != PW'(MAX_PREDIV));
          if (div_done) begin
            if (mint >= pds_pkg::MINT_MIN) begin
              pcode_q  <= pm1_ext[4:0];
              icode_q  <= mint - pds_pkg::MINT_MIN;
              frac_q   <= quot_lo[15:0];
              status_q <= pds_pkg::ST_OK;
              state_q  <= S_DONE;
            end else if (p_q == PW'(MAX_PREDIV)) begin
              pcode_q  <= '0;
              icode_q  <= '0;
              frac_q   <= '0;
              status_q <= pds_pkg::ST_NO_PDIV;
              state_q  <= S_DONE;
            end else begin
              // next predivider
              p_q             <= p_q + PW'(1);
              div_dvd_q       <= {ref_q, (pds_pkg::DVD_W - pds_pkg::REF_W)'(0)};
              div_dvs_q       <= pds_pkg::DVS_W'(p_q + PW'(1));
              div_req_q.steps <= pds_pkg::STEPS_REF;
              state_q         <= S_DREF;
            end
          end
        end
        S_DONE: begin
          div_req_q.start <= 1'b0;
          // wait for the output register to free up
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q  <= 1'b1;
            out_pcode_q  <= pcode_q;
            out_icode_q  <= icode_q;
            out_frac_q   <= frac_q;
            out_mode_q   <= mode_q;
            out_lowf_q   <= lowf_q;
            out_status_q <= status_q;
            state_q      <= S_IDLE;
          end
        end
        default: begin
          div_req_q.start <= 1'b0;
          state_q         <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign prediv_code_o = out_pcode_q;
  assign int_code_o    = out_icode_q;
  assign frac_part_o   = out_frac_q;
  assign vco_mode_on_o = out_mode_q;
  assign low_freq_on_o = out_lowf_q;
  assign status_o      = out_status_q;

endmodule

// ----- rtl/pds_checker.sv -----
// port-level checks of the pll divider search block, bound to the top level
`include "pll_divider_search_top_macros.svh"

module pds_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        ref_clock_hz_we_i,
  input logic [pds_pkg::REF_W-1:0]   ref_clock_hz_i,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic [pds_pkg::VCO_W-1:0]   vco_hz_i,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [4:0]                  prediv_code_o,
  input logic [15:0]                 int_code_o,
  input logic [15:0]                 frac_part_o,
  input logic                        vco_mode_on_o,
  input logic                        low_freq_on_o,
  input logic [1:0]                  status_o
);

  // a failed search reports zero divider fields
  `PDS_ASSERT(a_err_zero,
    (out_valid_o && status_o != pds_pkg::ST_OK) |->
      (prediv_code_o == 5'd0 && int_code_o == 16'd0 && frac_part_o == 16'd0),
    "error result with nonzero divider fields")

  // at or above the high threshold vco mode is off and the low frequency flag is set
  `PDS_ASSERT(a_flags, (out_valid_o && !vco_mode_on_o) |-> low_freq_on_o,
    "vco mode off without low frequency flag")

  // the search leaves idle on a transfer, so input stalls in the cycle after it
  `PDS_ASSERT(a_busy, (in_valid_i && !in_stall_o) |=> in_stall_o,
    "input not stalled after transfer")

  `PDS_ASSERT(a_out_hold, (out_valid_o && out_stall_i) |=> out_valid_o,
    "result dropped while stalled")

  `PDS_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> (!out_valid_o && !in_stall_o),
    "not idle in reset")

endmodule

bind pll_divider_search_top pds_checker u_pds_checker (.*);
